[rtl/dsu_pkg.sv]
package dsu_pkg;

  localparam int ELEM_W       = 8;
  localparam int MAX_DEPTH    = 256;
  localparam int ELEMENTS_DEF = 256;
  localparam int ALU_W        = ELEM_W + 1;

  localparam logic REQ_FIND  = 1'b0;
  localparam logic REQ_UNION = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ELEM_W-1:0] waddr;
    logic [ELEM_W-1:0] wdata;
    logic [ELEM_W-1:0] raddr;
  } mem_cmd_t;

endpackage

[rtl/dsu_req_if.sv]
interface dsu_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [dsu_pkg::ELEM_W-1:0] elem_a;
  logic [dsu_pkg::ELEM_W-1:0] elem_b;

  modport source (output valid, req_type, elem_a, elem_b, input ready);
  modport sink (input valid, req_type, elem_a, elem_b, output ready);
endinterface

[rtl/dsu_rsp_if.sv]
interface dsu_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [dsu_pkg::ELEM_W-1:0] root;
  logic                       joined;

  modport source (output valid, root, joined, input ready);
  modport sink (input valid, root, joined, output ready);
endinterface

[rtl/dsu_alu.sv]
module dsu_alu (
  input  logic [dsu_pkg::ALU_W-1:0] op_a,
  input  logic [dsu_pkg::ALU_W-1:0] op_b,
  output logic                      eq,
  output logic                      ge,
  output logic [dsu_pkg::ALU_W-1:0] diff
);

  logic [dsu_pkg::ALU_W:0] sub;

  assign sub  = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = ~sub[dsu_pkg::ALU_W];
  assign eq   = (op_a == op_b);
  assign diff = sub[dsu_pkg::ALU_W-1:0];

endmodule

[rtl/dsu_mem.sv]
module dsu_mem #(
  parameter int DEPTH = dsu_pkg::MAX_DEPTH
) (
  input  logic                       clk,
  input  dsu_pkg::mem_cmd_t          cmd,
  output logic [dsu_pkg::ELEM_W-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_q;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr[AW-1:0]] <= cmd.wdata[AW-1:0];
    end
    rdata_q <= mem[cmd.raddr[AW-1:0]];
  end

  assign rdata = dsu_pkg::ELEM_W'(rdata_q);

endmodule

[rtl/dsu_ctrl.sv]
module dsu_ctrl #(
  parameter int DEPTH = dsu_pkg::MAX_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  dsu_req_if.sink                    req,
  dsu_rsp_if.source                  rsp,
  output dsu_pkg::mem_cmd_t          cmd,
  input  logic [dsu_pkg::ELEM_W-1:0] rdata
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_RED   = 8'b00000100,
    S_WALK  = 8'b00001000,
    S_CHK   = 8'b00010000,
    S_WR    = 8'b00100000,
    S_LINK  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  localparam logic [dsu_pkg::ALU_W-1:0]  DEPTH_V = dsu_pkg::ALU_W'(DEPTH);
  localparam logic [dsu_pkg::ELEM_W-1:0] LAST    = dsu_pkg::ELEM_W'(DEPTH - 1);

  state_t                     state, state_next;
  logic [dsu_pkg::ELEM_W-1:0] cnt;
  logic                       op;
  logic                       phase;
  logic                       joined;
  logic [dsu_pkg::ELEM_W-1:0] b_q, cur, start, r, ra, rb;

  logic [dsu_pkg::ALU_W-1:0]  op_a, op_b, diff;
  logic                       eq, ge;

  dsu_alu u_alu (
    .op_a (op_a),
    .op_b (op_b),
    .eq   (eq),
    .ge   (ge),
    .diff (diff)
  );

  assign req.ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_WALK:  begin op_a = {1'b0, rdata}; op_b = {1'b0, r};  end
      S_CHK:   begin op_a = {1'b0, cur};   op_b = {1'b0, r};  end
      S_LINK:  begin op_a = {1'b0, ra};    op_b = {1'b0, rb}; end
      default: begin op_a = {1'b0, cur};   op_b = DEPTH_V;    end
    endcase
  end

  always_comb begin
    cmd.we    = 1'b0;
    cmd.waddr = cur;
    cmd.wdata = r;
    cmd.raddr = cur;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.we    = 1'b1;
        cmd.waddr = cnt;
        cmd.wdata = cnt;
        if (cnt == LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = S_RED;
      end
      S_RED: begin
        if (!ge) state_next = S_WALK;
      end
      S_WALK: begin
        cmd.raddr = rdata;
        if (eq) state_next = S_CHK;
      end
      S_CHK: begin
        if (!eq) begin
          state_next = S_WR;
        end else if (phase) begin
          state_next = S_LINK;
        end else if (op == dsu_pkg::REQ_UNION) begin
          state_next = S_RED;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WR: begin
        cmd.we     = 1'b1;
        state_next = S_CHK;
      end
      S_LINK: begin
        cmd.we     = !eq;
        cmd.waddr  = rb;
        cmd.wdata  = ra;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      case (state)
        S_CLEAR: cnt <= cnt + 1'b1;
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.req_type;
            cur   <= req.elem_a;
            b_q   <= req.elem_b;
            phase <= 1'b0;
          end
        end
        S_RED: begin
          if (ge) begin
            cur <= diff[dsu_pkg::ELEM_W-1:0];
          end else begin
            start <= cur;
            r     <= cur;
          end
        end
        S_WALK: begin
          if (eq) cur <= start;
          else    r   <= rdata;
        end
        S_CHK: begin
          if (eq) begin
            if (phase) begin
              rb <= r;
            end else begin
              ra     <= r;
              joined <= 1'b0;
              cur    <= b_q;
              phase  <= 1'b1;
            end
          end
        end
        S_WR:   cur    <= rdata;
        S_LINK: joined <= !eq;
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid  <= 1'b1;
            rsp.root   <= ra;
            rsp.joined <= joined;
          end
        end
        default: ;
      endcase
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !cmd.we)
    else $error("table written while idle");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.we |-> (int'(cmd.waddr) < DEPTH && int'(cmd.wdata) < DEPTH))
    else $error("table write out of range");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (int'(rdata) < DEPTH))
    else $error("parent link out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_RED))
    else $error("accepted beat did not start a request");

  a_join_on_union: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && joined) |-> (op == dsu_pkg::REQ_UNION))
    else $error("join reported for find");

endmodule

[rtl/disjoint_set_union_find.sv]
// disjoint-set engine with path compression over a parent table
// req channel: req_type (find or union), elem_a, elem_b; one beat per request
// rsp channel: root of elem_a's set and joined; exactly one beat per request
// elements are reduced modulo ELEMENTS; indexes from 256 up are never used
// after reset a clearing pass writes each of the min(ELEMENTS, 256) entries with
// its own index, during which req.ready stays low
// one request at a time: req.ready is high only while the engine is idle
// a find first reduces its element by repeated subtraction of ELEMENTS (none
// when ELEMENTS is 256 or more), walks the parent links up to the root, then
// walks the path again and writes the root into each entry below it; a union
// runs two finds and then a link step; every request also has an accept step
// and a result step; the single table port (one read and one write per cycle)
// and the shared compare unit set the pace of these steps
// the result sits in an output register; when rsp.ready is low the engine
// finishes the next request and waits with it until the register frees
module disjoint_set_union_find #(
  parameter int ELEMENTS = dsu_pkg::ELEMENTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dsu_req_if.sink   req,
  dsu_rsp_if.source rsp
);

  localparam int DEPTH = (ELEMENTS < dsu_pkg::MAX_DEPTH) ? ELEMENTS : dsu_pkg::MAX_DEPTH;

  dsu_pkg::mem_cmd_t          cmd;
  logic [dsu_pkg::ELEM_W-1:0] rdata;

  dsu_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .cmd   (cmd),
    .rdata (rdata)
  );

  dsu_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .cmd   (cmd),
    .rdata (rdata)
  );

endmodule
